// ----- hw/rtl/ucre_pkg.sv -----
package ucre_pkg;

  // Default width of the bit timers.
  localparam int TIMER_WIDTH_DEFAULT = 16;

  // Configuration register reset values.
  localparam logic [15:0] BIT_PERIOD_RESET      = 16'd109;
  localparam logic [15:0] HALF_BIT_PERIOD_RESET = 16'd55;

  // Configuration register indexes, taken from bit 2 of the byte address.
  localparam logic REG_BIT_PERIOD      = 1'b0;
  localparam logic REG_HALF_BIT_PERIOD = 1'b1;

  // Frame layout: start bit, eight data bits, stop bit.
  localparam logic [3:0] RX_FRAME_BITS = 4'd10;
  localparam logic [3:0] TX_SHIFT_BITS = 4'd9;

  // Drive pattern selected after reset and by the stop command.
  localparam logic [5:0] PATTERN_STOP = 6'h09;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // What the transmit shifter does on one tick.
  typedef enum logic [1:0] {
    TX_HOLD,
    TX_START,
    TX_SHIFT,
    TX_STOP
  } tx_act_t;

  // One classified tick handed from the front to the back.
  typedef struct packed {
    tx_act_t    act;
    logic [5:0] pattern;
    logic       byte_valid;
    logic [7:0] byte_value;
    logic       busy;
  } ucre_word_t;

  // Command letter to drive pattern; any other byte keeps the current one.
  function automatic logic [5:0] pattern_for(input logic [7:0] b, input logic [5:0] cur);
    logic [5:0] p;
    unique case (b)
      8'h66:   p = 6'h24; // 'f'
      8'h62:   p = 6'h12; // 'b'
      8'h6c:   p = 6'h28; // 'l'
      8'h72:   p = 6'h05; // 'r'
      8'h73:   p = PATTERN_STOP; // 's'
      8'h78:   p = 6'h22; // 'x'
      8'h79:   p = 6'h14; // 'y'
      8'h31:   p = 6'h18; // '1'
      8'h32:   p = 6'h03; // '2'
      default: p = cur;
    endcase
    return p;
  endfunction

endpackage

// ----- hw/rtl/ucre_front.sv -----
module ucre_front #(
  parameter int TIMER_WIDTH = ucre_pkg::TIMER_WIDTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic                 rx_level,
  input  logic [15:0]          bit_period,
  input  logic [15:0]          half_bit_period,
  output ucre_pkg::ucre_word_t word
);
  import ucre_pkg::*;

  logic                   prev_rx, prev_rx_next;
  logic                   rx_active, rx_active_next;
  logic [TIMER_WIDTH-1:0] rx_count, rx_count_next;
  logic [3:0]             rx_bits_left, rx_bits_left_next;
  logic [9:0]             rx_frame, rx_frame_next;
  logic                   tx_active, tx_active_next;
  logic [TIMER_WIDTH-1:0] tx_count, tx_count_next;
  logic [3:0]             tx_bits_left, tx_bits_left_next;
  logic [5:0]             pattern, pattern_next;
  logic [7:0]             last_byte, last_byte_next;
  logic [9:0]             rx_frame_shift;
  logic                   fall;
  logic                   idle;
  logic                   byte_ok;
  tx_act_t                act;

  // A period of zero counts as one tick.
  function automatic logic [TIMER_WIDTH-1:0] load_count(input logic [15:0] v);
    logic [TIMER_WIDTH-1:0] c;
    c = TIMER_WIDTH'(v);
    return (c == '0) ? TIMER_WIDTH'(1) : c;
  endfunction

  assign fall           = prev_rx && !rx_level;
  assign idle           = !rx_active && !tx_active;
  assign rx_frame_shift = {rx_level, rx_frame[9:1]};

  // Receiver and transmit timing for one tick.
  always_comb begin
    prev_rx_next      = rx_level;
    rx_active_next    = rx_active;
    rx_count_next     = rx_count;
    rx_bits_left_next = rx_bits_left;
    rx_frame_next     = rx_frame;
    tx_active_next    = tx_active;
    tx_count_next     = tx_count;
    tx_bits_left_next = tx_bits_left;
    pattern_next      = pattern;
    last_byte_next    = last_byte;
    byte_ok           = 1'b0;
    act               = TX_HOLD;

    // Transmit bit timer.
    if (tx_active) begin
      if (tx_count <= TIMER_WIDTH'(1)) begin
        if (tx_bits_left == 4'd0) begin
          tx_active_next = 1'b0;
          tx_count_next  = '0;
          act            = TX_STOP;
        end else begin
          tx_bits_left_next = tx_bits_left - 4'd1;
          tx_count_next     = load_count(bit_period);
          act               = TX_SHIFT;
        end
      end else begin
        tx_count_next = tx_count - TIMER_WIDTH'(1);
      end
    end

    // Receive sampling; a finished, well framed byte starts the echo.
    if (rx_active) begin
      if (rx_count <= TIMER_WIDTH'(1)) begin
        rx_frame_next     = rx_frame_shift;
        rx_bits_left_next = rx_bits_left - 4'd1;
        rx_count_next     = load_count(bit_period);
        if (rx_bits_left_next == 4'd0) begin
          rx_active_next = 1'b0;
          rx_count_next  = '0;
          if (!rx_frame_shift[0] && rx_frame_shift[9]) begin
            last_byte_next    = rx_frame_shift[8:1];
            pattern_next      = pattern_for(rx_frame_shift[8:1], pattern);
            byte_ok           = 1'b1;
            act               = TX_START;
            tx_active_next    = 1'b1;
            tx_bits_left_next = TX_SHIFT_BITS;
            tx_count_next     = load_count(bit_period);
          end
        end
      end else begin
        rx_count_next = rx_count - TIMER_WIDTH'(1);
      end
    end else if (idle && fall) begin
      rx_active_next    = 1'b1;
      rx_frame_next     = '0;
      rx_bits_left_next = RX_FRAME_BITS;
      rx_count_next     = load_count(half_bit_period);
    end
  end

  // Word for the back: shifter action and the status seen after this tick.
  always_comb begin
    word.act        = act;
    word.pattern    = pattern_next;
    word.byte_valid = byte_ok;
    word.byte_value = last_byte_next;
    word.busy       = rx_active_next || tx_active_next;
  end

  // State advances once per accepted tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_rx      <= 1'b1;
      rx_active    <= 1'b0;
      rx_count     <= '0;
      rx_bits_left <= '0;
      rx_frame     <= '0;
      tx_active    <= 1'b0;
      tx_count     <= '0;
      tx_bits_left <= '0;
      pattern      <= PATTERN_STOP;
      last_byte    <= '0;
    end else if (accept) begin
      prev_rx      <= prev_rx_next;
      rx_active    <= rx_active_next;
      rx_count     <= rx_count_next;
      rx_bits_left <= rx_bits_left_next;
      rx_frame     <= rx_frame_next;
      tx_active    <= tx_active_next;
      tx_count     <= tx_count_next;
      tx_bits_left <= tx_bits_left_next;
      pattern      <= pattern_next;
      last_byte    <= last_byte_next;
    end
  end

  // The link is half duplex: never receiving and transmitting together.
  a_half_duplex: assert property (@(posedge clk) disable iff (rst)
    !(rx_active && tx_active))
    else $error("Receiver and transmitter active together.");

  // The transmit bit count never exceeds the bits after the start bit.
  a_tx_bits: assert property (@(posedge clk) disable iff (rst)
    tx_bits_left <= TX_SHIFT_BITS)
    else $error("Transmit bit count out of range.");

  // A good byte always launches an echo frame.
  a_echo: assert property (@(posedge clk) disable iff (rst)
    (accept && byte_ok) |=> tx_active)
    else $error("Received byte did not start the echo.");

endmodule

// ----- hw/rtl/ucre_queue.sv -----
module ucre_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  ucre_pkg::ucre_word_t push_word,
  input  logic                 pop,
  output ucre_pkg::ucre_word_t head,
  output logic                 full,
  output logic                 empty
);
  import ucre_pkg::*;

  ucre_word_t             slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic                   push_ok;
  logic                   pop_ok;

  assign full    = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign head    = slots[rd_ptr];

  function automatic logic [QUEUE_PTR_W-1:0] bump(input logic [QUEUE_PTR_W-1:0] p);
    return (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QUEUE_PTR_W'(1);
  endfunction

  // Storage for the words in flight.
  always_ff @(posedge clk) begin
    if (push_ok) begin
      slots[wr_ptr] <= push_word;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop_ok) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push_ok && !pop_ok) begin
        count <= count + QUEUE_CNT_W'(1);
      end else if (pop_ok && !push_ok) begin
        count <= count - QUEUE_CNT_W'(1);
      end
    end
  end

  // Fill level stays within the depth.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= QUEUE_CNT_W'(QUEUE_DEPTH))
    else $error("Queue fill level out of range.");

  // A pop without a push lowers the fill level by one.
  a_pop_only: assert property (@(posedge clk) disable iff (rst)
    (pop_ok && !push_ok) |=> (count == $past(count) - QUEUE_CNT_W'(1)))
    else $error("Queue fill level did not drop on pop.");

  // The head word holds while it is not taken.
  a_head_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> $stable(head))
    else $error("Queue head changed while not popped.");

endmodule

// ----- hw/rtl/ucre_back.sv -----
module ucre_back (
  input  logic                 clk,
  input  logic                 rst,
  input  ucre_pkg::ucre_word_t head,
  input  logic                 empty,
  output logic                 pop,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic                 tx_level,
  output logic [5:0]           motor_pattern,
  output logic                 byte_valid,
  output logic [7:0]           byte_value,
  output logic                 busy_res
);
  import ucre_pkg::*;

  logic [8:0] tx_frame;

  // Take the next word whenever the output register is free or being read.
  assign pop = !empty && (!out_valid || !out_stall);

  // Output handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Transmit shifter; the line register is also the transmit output.
  always_ff @(posedge clk) begin
    if (rst) begin
      tx_level <= 1'b1;
      tx_frame <= '0;
    end else if (pop) begin
      unique case (head.act)
        TX_START: begin
          tx_level <= 1'b0;
          tx_frame <= {1'b1, head.byte_value};
        end
        TX_SHIFT: begin
          tx_level <= tx_frame[0];
          tx_frame <= {1'b0, tx_frame[8:1]};
        end
        TX_STOP: begin
          tx_level <= 1'b1;
        end
        TX_HOLD: begin
          tx_level <= tx_level;
        end
        default: begin
          tx_level <= tx_level;
        end
      endcase
    end
  end

  // Status fields of the result word.
  always_ff @(posedge clk) begin
    if (pop) begin
      motor_pattern <= head.pattern;
      byte_valid    <= head.byte_valid;
      byte_value    <= head.byte_value;
      busy_res      <= head.busy;
    end
  end

endmodule

// ----- hw/rtl/uart_command_receiver_echo.sv -----
// Channel  Direction  Handshake              Word contents
// in       input      in_valid / in_stall    rx_level, one line sample per tick
// out      output     out_valid / out_stall  tx_level, motor_pattern, byte_valid,
//                                            byte_value, busy_res
// cfg      input      APB, pready tied high  bit_period (0x0), half_bit_period (0x4)
//
// One input word is taken per clock while in_stall is low; the front updates the
// receiver and the transmit timer for each accepted word, so the sustained rate is
// one word per clock unless the output stalls. An accepted input word is registered
// in the queue between front and back, then in the output register of the back.
// Reset is synchronous and clears all control state at once; no clearing pass.
// The two-entry queue absorbs a stall on the output; in_stall rises only when
// it is full.
module uart_command_receiver_echo #(
  parameter int TIMER_WIDTH = ucre_pkg::TIMER_WIDTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        rx_level,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        tx_level,
  output logic [5:0]  motor_pattern,
  output logic        byte_valid,
  output logic [7:0]  byte_value,
  output logic        busy_res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ucre_pkg::*;

  logic [15:0] bit_period;
  logic [15:0] half_bit_period;
  logic        accept;
  logic        cfg_write;
  logic        q_full;
  logic        q_empty;
  logic        q_pop;
  ucre_word_t  front_word;
  ucre_word_t  q_head;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign in_stall  = q_full;
  assign accept    = in_valid && !in_stall;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_period      <= BIT_PERIOD_RESET;
      half_bit_period <= HALF_BIT_PERIOD_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_BIT_PERIOD:      bit_period      <= pwdata[15:0];
        REG_HALF_BIT_PERIOD: half_bit_period <= pwdata[15:0];
        default:             bit_period      <= bit_period;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (paddr[2])
      REG_BIT_PERIOD:      prdata = {16'd0, bit_period};
      REG_HALF_BIT_PERIOD: prdata = {16'd0, half_bit_period};
      default:             prdata = '0;
    endcase
  end

  ucre_front #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .rx_level        (rx_level),
    .bit_period      (bit_period),
    .half_bit_period (half_bit_period),
    .word            (front_word)
  );

  ucre_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_word (front_word),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  ucre_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (q_head),
    .empty         (q_empty),
    .pop           (q_pop),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .tx_level      (tx_level),
    .motor_pattern (motor_pattern),
    .byte_valid    (byte_valid),
    .byte_value    (byte_value),
    .busy_res      (busy_res)
  );

endmodule

// ----- tb/uart_command_receiver_echo_tb.sv -----
`timescale 1ns / 1ps

module uart_command_receiver_echo_tb;
  import ucre_pkg::*;

  localparam int CYCLE_LIMIT      = 4000000;
  localparam int PHASE_TICKS      = 80;
  localparam int RANDOM_PHASES    = 5;
  localparam int LONG_HOLD_CYCLES = 60;
  localparam int MAX_REPORTS      = 40;

  // Command letters that select a drive pattern: f b l r s x y 1 2.
  localparam logic [7:0] CMD_LETTERS [9] = '{8'h66, 8'h62, 8'h6c, 8'h72, 8'h73,
                                              8'h78, 8'h79, 8'h31, 8'h32};

  // One output word of the block as it should appear.
  typedef struct packed {
    logic       tx;
    logic [5:0] pattern;
    logic       valid;
    logic [7:0] value;
    logic       busy;
  } line_state_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        rx_level = 1'b1;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        tx_level;
  logic [5:0]  motor_pattern;
  logic        byte_valid;
  logic [7:0]  byte_value;
  logic        busy_res;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Line levels still to be offered, and the output words still owed.
  logic        line_ticks [$];
  line_state_t predicted [$];

  int cycles = 0;
  int errors = 0;
  int words_checked = 0;
  int ticks_queued = 0;
  int frames_sent = 0;
  int bytes_echoed = 0;
  int settings_used = 0;
  int gap_left = 0;
  int hold_left = 0;
  int long_req = 0;
  int long_seen = 0;

  // Predictor copy of the registers and of the receiver and transmitter.
  logic [15:0] bit_period_q;
  logic [15:0] half_period_q;
  logic        rx_on;
  logic [15:0] rx_count;
  logic [3:0]  rx_left;
  logic [9:0]  rx_shift;
  logic        line_prev;
  logic        tx_on;
  logic [15:0] tx_count;
  logic [3:0]  tx_left;
  logic [9:0]  tx_shift;
  logic        tx_out;
  logic [5:0]  drive_q;
  logic [7:0]  last_q;

  uart_command_receiver_echo u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .rx_level      (rx_level),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .tx_level      (tx_level),
    .motor_pattern (motor_pattern),
    .byte_valid    (byte_valid),
    .byte_value    (byte_value),
    .busy_res      (busy_res),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Cycle count and the overall time limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("run stopped at the cycle limit with %0d words owed", predicted.size());
      $display("FAILURE");
      $finish;
    end
  end

  // A zero period counts as one tick.
  function automatic logic [15:0] timer_load(input logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

  // Letter lookup; any other byte leaves the pattern as it was.
  function automatic logic [5:0] command_drive(input logic [7:0] b, input logic [5:0] cur);
    case (b)
      8'h66:   return 6'h24;
      8'h62:   return 6'h12;
      8'h6c:   return 6'h28;
      8'h72:   return 6'h05;
      8'h73:   return 6'h09;
      8'h78:   return 6'h22;
      8'h79:   return 6'h14;
      8'h31:   return 6'h18;
      8'h32:   return 6'h03;
      default: return cur;
    endcase
  endfunction

  task automatic predictor_reset();
    bit_period_q  = BIT_PERIOD_RESET;
    half_period_q = HALF_BIT_PERIOD_RESET;
    rx_on     = 1'b0;
    rx_count  = '0;
    rx_left   = '0;
    rx_shift  = '0;
    line_prev = 1'b1;
    tx_on     = 1'b0;
    tx_count  = '0;
    tx_left   = '0;
    tx_shift  = '0;
    tx_out    = 1'b1;
    drive_q   = PATTERN_STOP;
    last_q    = '0;
  endtask

  // Advance the line model by one accepted tick and queue the word it gives.
  task automatic uart_predict(input logic lvl);
    logic fall;
    logic got;
    logic idle;
    fall = line_prev && !lvl;
    got  = 1'b0;
    idle = !rx_on && !tx_on;

    // Transmitter: hold each bit for one bit time, then return to mark.
    if (tx_on) begin
      if (tx_count <= 16'd1) begin
        if (tx_left == 4'd0) begin
          tx_on    = 1'b0;
          tx_out   = 1'b1;
          tx_count = '0;
        end else begin
          tx_out   = tx_shift[0];
          tx_shift = tx_shift >> 1;
          tx_left  = tx_left - 4'd1;
          tx_count = timer_load(bit_period_q);
        end
      end else begin
        tx_count = tx_count - 16'd1;
      end
    end

    // Receiver: sample ten times, keep the byte only with a low start and a high stop.
    if (rx_on) begin
      if (rx_count <= 16'd1) begin
        rx_shift = {lvl, rx_shift[9:1]};
        rx_left  = rx_left - 4'd1;
        rx_count = timer_load(bit_period_q);
        if (rx_left == 4'd0) begin
          rx_on    = 1'b0;
          rx_count = '0;
          if (!rx_shift[0] && rx_shift[9]) begin
            last_q   = rx_shift[8:1];
            drive_q  = command_drive(last_q, drive_q);
            got      = 1'b1;
            tx_out   = 1'b0;
            tx_shift = {2'b01, last_q};
            tx_left  = TX_SHIFT_BITS;
            tx_count = timer_load(bit_period_q);
            tx_on    = 1'b1;
            bytes_echoed++;
          end
        end
      end else begin
        rx_count = rx_count - 16'd1;
      end
    end else if (idle && fall) begin
      rx_on    = 1'b1;
      rx_shift = '0;
      rx_left  = RX_FRAME_BITS;
      rx_count = timer_load(half_period_q);
    end

    line_prev = lvl;
    predicted.push_back('{tx_out, drive_q, got, last_q, rx_on | tx_on});
  endtask

  task automatic report(input string what, input int unsigned got, input int unsigned want);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("mismatch in %s at word %0d: got 0x%0h, expected 0x%0h",
               what, words_checked, got, want);
  endtask

  // Sender offers without gaps for whole stretches, otherwise draws a gap per word.
  function automatic int sender_wait();
    if ((cycles / 700) % 3 == 0) return 0;
    return $urandom_range(0, 5);
  endfunction

  function automatic int receiver_wait();
    if ((cycles / 1100) % 3 == 1) return 0;
    return $urandom_range(0, 5);
  endfunction

  // Driver: offer the next line level, hold it while stalled.
  always @(posedge clk) begin : line_driver
    logic taken;
    taken = in_valid && !in_stall;
    if (rst) begin
      in_valid <= 1'b0;
      rx_level <= 1'b1;
      gap_left <= 0;
      predictor_reset();
    end else begin
      if (taken) uart_predict(rx_level);
      if (!in_valid || taken) begin
        if (gap_left != 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (line_ticks.size() != 0) begin
          in_valid <= 1'b1;
          rx_level <= line_ticks.pop_front();
          gap_left <= sender_wait();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output stall: a drawn wait after each word, or a long hold on request.
  always @(posedge clk) begin : result_stall
    int n;
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      long_seen <= 0;
    end else begin
      n = hold_left;
      if (long_seen != long_req) begin
        long_seen <= long_req;
        n = LONG_HOLD_CYCLES;
      end else if (out_valid && !out_stall) begin
        n = receiver_wait();
      end
      if (n != 0) begin
        out_stall <= 1'b1;
        hold_left <= n - 1;
      end else begin
        out_stall <= 1'b0;
        hold_left <= 0;
      end
    end
  end

  // Monitor: compare each accepted word with the oldest prediction.
  always @(posedge clk) begin : result_check
    line_state_t want;
    if (!rst && out_valid && !out_stall) begin
      if (predicted.size() == 0) begin
        report("unexpected word", tx_level, 0);
      end else begin
        want = predicted.pop_front();
        if (tx_level !== want.tx) report("tx_level", tx_level, want.tx);
        if (motor_pattern !== want.pattern) report("motor_pattern", motor_pattern, want.pattern);
        if (byte_valid !== want.valid) report("byte_valid", byte_valid, want.valid);
        if (byte_value !== want.value) report("byte_value", byte_value, want.value);
        if (busy_res !== want.busy) report("busy_res", busy_res, want.busy);
      end
      words_checked++;
    end
  end

  task automatic push_line(input logic lvl);
    line_ticks.push_back(lvl);
    ticks_queued++;
  endtask

  // Ticks of mark long enough for the echo to finish before the next start edge.
  function automatic int echo_span();
    return 10 * timer_load(bit_period_q) + 2 + $urandom_range(0, 3);
  endfunction

  function automatic logic [7:0] pick_byte();
    if ($urandom_range(0, 1) == 0) return CMD_LETTERS[$urandom_range(0, 8)];
    return 8'($urandom_range(0, 255));
  endfunction

  // A frame laid out so that each sample point falls at the start of its bit.
  task automatic push_frame(input logic [7:0] data, input logic start_v, input logic stop_v,
                            input int trailing);
    logic [9:0] bits;
    int h;
    int b;
    bits = {stop_v, data, start_v};
    h = timer_load(half_period_q);
    b = timer_load(bit_period_q);
    repeat (1 + $urandom_range(0, 2)) push_line(1'b1);
    for (int j = 0; j < h + 10 * b; j++)
      push_line(j < h ? 1'b0 : bits[(j - h) / b]);
    repeat (trailing) push_line(1'b1);
    frames_sent++;
  endtask

  task automatic wait_drained();
    while (line_ticks.size() != 0 || in_valid || predicted.size() != 0) @(posedge clk);
  endtask

  // Keep the line at mark until neither side of the UART is busy.
  task automatic settle_idle();
    wait_drained();
    while (rx_on || tx_on) begin
      repeat (8) push_line(1'b1);
      wait_drained();
    end
    repeat (4) @(posedge clk);
  endtask

  // Register write followed by a read back of the same register.
  task automatic cfg_write(input logic idx, input logic [15:0] value);
    logic [31:0] back;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'h0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    psel    <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    back = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (back !== {16'h0, value}) report("register read back", back, value);
    if (idx == REG_BIT_PERIOD) bit_period_q = value;
    else half_period_q = value;
  endtask

  task automatic configure(input logic [15:0] bit_ticks, input logic [15:0] half_ticks);
    cfg_write(REG_BIT_PERIOD, bit_ticks);
    cfg_write(REG_HALF_BIT_PERIOD, half_ticks);
    settings_used++;
  endtask

  initial begin : stimulus
    int b;
    int start;
    int mid;
    int kind;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Line held at mark under the reset bit timing.
    repeat (24) push_line(1'b1);
    settle_idle();

    // Short bit time: byte extremes, every letter, framing errors.
    configure(16'd2, 16'd1);
    push_frame(8'h00, 1'b0, 1'b1, echo_span());
    push_frame(8'hff, 1'b0, 1'b1, echo_span());
    foreach (CMD_LETTERS[i]) push_frame(CMD_LETTERS[i], 1'b0, 1'b1, echo_span());
    push_frame(8'h7a, 1'b0, 1'b1, echo_span());
    push_frame(8'h5a, 1'b1, 1'b1, echo_span());
    push_frame(8'ha5, 1'b0, 1'b0, echo_span());
    // A second start edge while the first byte is still being echoed.
    push_frame(8'h62, 1'b0, 1'b1, 2);
    push_frame(8'h6c, 1'b0, 1'b1, echo_span());
    settle_idle();

    // Shortest periods, then zero periods which act as one tick.
    configure(16'd1, 16'd1);
    repeat (3) push_frame(pick_byte(), 1'b0, 1'b1, echo_span());
    settle_idle();
    configure(16'd0, 16'd0);
    repeat (3) push_frame(pick_byte(), 1'b0, 1'b1, echo_span());
    settle_idle();

    // Full-scale bit period with the line left at mark.
    configure(16'hffff, 16'd1);
    repeat (20) push_line(1'b1);
    settle_idle();

    // Full-scale wait before the first sample, with the line left at mark.
    configure(16'd3, 16'hffff);
    repeat (20) push_line(1'b1);
    settle_idle();

    // Random phases: mostly clean frames, some early edges, bad frames and noise.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      b = $urandom_range(1, 4);
      configure(16'(b), 16'($urandom_range(0, b + 1)));
      start = ticks_queued;
      mid = 0;
      while (ticks_queued - start < PHASE_TICKS) begin
        if (p % 3 == 2 && mid == 0 && ticks_queued - start >= PHASE_TICKS / 2) begin
          wait_drained();
          mid = 1;
        end
        kind = $urandom_range(0, 19);
        if (kind < 12)
          push_frame(pick_byte(), 1'b0, 1'b1, echo_span());
        else if (kind < 14)
          push_frame(pick_byte(), 1'b0, 1'b1, $urandom_range(0, 2 * b));
        else if (kind == 14)
          push_frame(pick_byte(), 1'b1, 1'b1, $urandom_range(1, 12 * b));
        else if (kind == 15)
          push_frame(pick_byte(), 1'b0, 1'b0, $urandom_range(1, 12 * b));
        else
          repeat ($urandom_range(1, 3 * b)) push_line(1'($urandom_range(0, 1)));
      end
      // Hold the output off while the sender keeps offering, so the input stalls.
      if (p % 3 == 1) long_req++;
      settle_idle();
    end

    settle_idle();
    repeat (8) @(posedge clk);
    $display("Checked %0d output words from %0d line ticks; %0d frames sent, %0d bytes echoed.",
             words_checked, ticks_queued, frames_sent, bytes_echoed);
    $display("Covered %0d timing settings, among them zero, one and full-scale periods.",
             settings_used);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
